### hw/rtl/gdfo_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// gdfo_pkg
// Shared types and codes for the depth-first order unit.
// ============================================================================
package gdfo_pkg;

    localparam int VERTEX_W = 6;
    localparam int STATUS_W = 2;
    localparam int VCOUNT_W = 7;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

    // opcodes
    localparam logic OP_ADD_EDGE = 1'b0;
    localparam logic OP_RUN      = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_VERTEX  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EDGE_OK = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ID  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic                opcode;
        logic [VERTEX_W-1:0] source_vertex;
        logic [VERTEX_W-1:0] target_vertex;
    } cmd_t;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex_id;
        logic [STATUS_W-1:0] status;
        logic                last;
    } result_t;

endpackage

### hw/rtl/gdfo_edge_store.sv
`timescale 1ns / 1ps
// ============================================================================
// gdfo_edge_store
// Linked edge store: target vertex and next-edge link per stored edge.
// ============================================================================
module gdfo_edge_store #(
    parameter int NUM_EDGES = 256,
    parameter int EDGE_W    = 8,
    parameter int TGT_W     = 6
) (
    input  logic              clk,
    input  logic              target_we,
    input  logic [EDGE_W-1:0] target_waddr,
    input  logic [TGT_W-1:0]  target_wdata,
    input  logic              link_we,
    input  logic [EDGE_W-1:0] link_waddr,
    input  logic [EDGE_W-1:0] link_wdata,
    input  logic [EDGE_W-1:0] raddr,
    output logic [TGT_W-1:0]  target_rd,
    output logic [EDGE_W-1:0] link_rd
);

    logic [TGT_W-1:0]  target_mem [NUM_EDGES];
    logic [EDGE_W-1:0] link_mem   [NUM_EDGES];
    logic [TGT_W-1:0]  target_rd_reg;
    logic [EDGE_W-1:0] link_rd_reg;

    always_ff @(posedge clk)
    begin
        if (target_we)
        begin
            target_mem[target_waddr] <= target_wdata;
        end
        target_rd_reg <= target_mem[raddr];
    end

    // link of an edge is written only when a later edge joins its list
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rd_reg <= link_mem[raddr];
    end

    assign target_rd = target_rd_reg;
    assign link_rd   = link_rd_reg;

endmodule

### hw/rtl/graph_depth_first_order.sv
`timescale 1ns / 1ps
// ============================================================================
// graph_depth_first_order
// Directed graph loader and depth-first traversal sequencer.
// ============================================================================
// Usage: a transaction is taken when start is high and busy is low. An add-edge
// transaction appends the edge to the source vertex's adjacency list and
// answers with one result (status edge accepted, bad vertex id or edge store
// full, last set). A run transaction walks the graph depth-first from vertex 0
// and emits one result per visited vertex, the final one with last set, and
// at most vertex_count results, clamped to 1 .. MAX_VERTICES. Results are
// one-cycle strobes on result_valid and cannot be held off, so the receiver
// must take them as they come. A single sequencer steps one edge per cycle
// through the single-read-port edge store and moves discovered vertices onto
// the worklist one at a time. No clearing pass is needed after reset;
// vertex_count may only be written while busy is low and no result is
// pending.
// ============================================================================
module graph_depth_first_order #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  gdfo_pkg::cmd_t                    cmd,
    output logic                              result_valid,
    output gdfo_pkg::result_t                 result,
    input  logic                              cfg_we,
    input  logic [gdfo_pkg::VCOUNT_W-1:0]     cfg_data
);

    localparam int VW    = $clog2(MAX_VERTICES);          // vertex index
    localparam int CW    = $clog2(MAX_VERTICES + 1);      // vertex counts
    localparam int EW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int SW    = $clog2(MAX_EDGES + 1);         // edges stored
    localparam int SUM_W = CW + 1;
    localparam int NW    = gdfo_pkg::VCOUNT_W;

    // sequencer states
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_ADD       = 4'd1;
    localparam logic [3:0] S_INIT      = 4'd2;
    localparam logic [3:0] S_POP_RD    = 4'd3;
    localparam logic [3:0] S_POP       = 4'd4;
    localparam logic [3:0] S_SCAN_HEAD = 4'd5;
    localparam logic [3:0] S_SCAN      = 4'd6;
    localparam logic [3:0] S_COPY_RD   = 4'd7;
    localparam logic [3:0] S_COPY_WR   = 4'd8;
    localparam logic [3:0] S_FINISH    = 4'd9;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [3:0]              state_reg, state_next;
    logic [NW-1:0]           vcount_reg;
    logic [SW-1:0]           edges_stored_reg, edges_stored_next;
    logic [MAX_VERTICES-1:0] first_valid_reg, first_valid_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [CW-1:0]           wl_size_reg, wl_size_next;
    logic [CW-1:0]           found_reg, found_next;
    logic [CW-1:0]           emitted_reg, emitted_next;
    logic                    pending_valid_reg, pending_valid_next;
    logic [VW-1:0]           pending_reg, pending_next;
    logic [EW-1:0]           cur_edge_reg, cur_edge_next;
    logic                    result_valid_reg, result_valid_next;
    gdfo_pkg::result_t       result_reg, result_next;
    logic [gdfo_pkg::VERTEX_W-1:0] src_reg, dst_reg;

    // per-vertex list heads/tails, worklist stack and discovery buffer
    logic [EW-1:0] first_mem [MAX_VERTICES];
    logic [EW-1:0] tail_mem  [MAX_VERTICES];
    logic [VW-1:0] wl_mem    [MAX_VERTICES];
    logic [VW-1:0] fresh_mem [MAX_VERTICES];
    logic [EW-1:0] first_rd_reg, tail_rd_reg;
    logic [VW-1:0] wl_rd_reg, fresh_rd_reg;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic [CW-1:0] active_n;
    logic [NW-1:0] n_ext;
    logic          accept;
    logic          bad_id;
    logic          store_full;
    logic [EW-1:0] new_edge;
    logic [VW-1:0] src_idx;
    logic [VW-1:0] scan_tgt;
    logic [EW-1:0] scan_link;
    logic          tgt_fresh;

    logic          first_we, tail_we, wl_we, fresh_we;
    logic          etgt_we, elink_we;
    logic [VW-1:0] tail_raddr, wl_waddr, wl_wdata, wl_raddr, fresh_raddr;
    logic [EW-1:0] edge_raddr;

    // vertex count clamped to 1 .. MAX_VERTICES
    always_comb
    begin
        if (vcount_reg == '0)
        begin
            active_n = CW'(1);
        end
        else if (vcount_reg > NW'(MAX_VERTICES))
        begin
            active_n = CW'(MAX_VERTICES);
        end
        else
        begin
            active_n = vcount_reg[CW-1:0];
        end
    end

    assign n_ext      = NW'(active_n);
    assign accept     = start && !busy;
    assign bad_id     = (NW'(src_reg) >= n_ext) || (NW'(dst_reg) >= n_ext);
    assign store_full = (edges_stored_reg == SW'(MAX_EDGES));
    assign new_edge   = edges_stored_reg[EW-1:0];
    assign src_idx    = src_reg[VW-1:0];
    assign tgt_fresh  = (NW'(scan_tgt) < n_ext) && !visited_reg[scan_tgt];

    assign tail_raddr  = (state_reg == S_IDLE) ? VW'(cmd.source_vertex) :
                         (state_reg == S_POP)  ? wl_rd_reg : pending_reg;
    assign wl_raddr    = VW'(wl_size_reg - CW'(1));
    assign fresh_raddr = VW'(found_reg - CW'(1));
    assign edge_raddr  = (state_reg == S_SCAN_HEAD) ? first_rd_reg : scan_link;
    assign wl_waddr    = (state_reg == S_INIT) ? '0 : wl_size_reg[VW-1:0];
    assign wl_wdata    = (state_reg == S_INIT) ? '0 : fresh_rd_reg;

    // ------------------------------------------------------------------
    // Edge store
    // ------------------------------------------------------------------
    gdfo_edge_store #(
        .NUM_EDGES (MAX_EDGES),
        .EDGE_W    (EW),
        .TGT_W     (VW)
    ) u_edge_store (
        .clk          (clk),
        .target_we    (etgt_we),
        .target_waddr (new_edge),
        .target_wdata (dst_reg[VW-1:0]),
        .link_we      (elink_we),
        .link_waddr   (tail_rd_reg),
        .link_wdata   (new_edge),
        .raddr        (edge_raddr),
        .target_rd    (scan_tgt),
        .link_rd      (scan_link)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next         = state_reg;
        edges_stored_next  = edges_stored_reg;
        first_valid_next   = first_valid_reg;
        visited_next       = visited_reg;
        wl_size_next       = wl_size_reg;
        found_next         = found_reg;
        emitted_next       = emitted_reg;
        pending_valid_next = pending_valid_reg;
        pending_next       = pending_reg;
        cur_edge_next      = cur_edge_reg;
        result_valid_next  = 1'b0;
        result_next        = result_reg;
        first_we           = 1'b0;
        tail_we            = 1'b0;
        wl_we              = 1'b0;
        fresh_we           = 1'b0;
        etgt_we            = 1'b0;
        elink_we           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (cmd.opcode == gdfo_pkg::OP_RUN) ? S_INIT : S_ADD;
                end
            end

            S_ADD:
            begin
                result_valid_next     = 1'b1;
                result_next.vertex_id = '0;
                result_next.last      = 1'b1;
                if (bad_id)
                begin
                    result_next.status = gdfo_pkg::ST_BAD_ID;
                end
                else if (store_full)
                begin
                    result_next.status = gdfo_pkg::ST_FULL;
                end
                else
                begin
                    result_next.status = gdfo_pkg::ST_EDGE_OK;
                    etgt_we = 1'b1;
                    tail_we = 1'b1;
                    if (first_valid_reg[src_idx])
                    begin
                        elink_we = 1'b1;     // old tail now points at new edge
                    end
                    else
                    begin
                        first_we                  = 1'b1;
                        first_valid_next[src_idx] = 1'b1;
                    end
                    edges_stored_next = edges_stored_reg + SW'(1);
                end
                state_next = S_IDLE;
            end

            S_INIT:
            begin
                visited_next       = '0;
                visited_next[0]    = 1'b1;
                wl_we              = 1'b1;
                wl_size_next       = CW'(1);
                emitted_next       = '0;
                pending_valid_next = 1'b0;
                found_next         = '0;
                state_next         = S_POP_RD;
            end

            S_POP_RD:
            begin
                wl_size_next = wl_size_reg - CW'(1);
                state_next   = S_POP;
            end

            S_POP:
            begin
                // previous vertex is known not to be the final one
                if (pending_valid_reg)
                begin
                    result_valid_next     = 1'b1;
                    result_next.vertex_id = gdfo_pkg::VERTEX_W'(pending_reg);
                    result_next.status    = gdfo_pkg::ST_VERTEX;
                    result_next.last      = 1'b0;
                end
                pending_next       = wl_rd_reg;
                pending_valid_next = 1'b1;
                emitted_next       = emitted_reg + CW'(1);
                found_next         = '0;
                if (CW'(emitted_reg + CW'(1)) == active_n)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN_HEAD;
                end
            end

            S_SCAN_HEAD:
            begin
                if (first_valid_reg[pending_reg])
                begin
                    cur_edge_next = first_rd_reg;
                    state_next    = S_SCAN;
                end
                else
                begin
                    state_next = S_COPY_RD;
                end
            end

            S_SCAN:
            begin
                if (tgt_fresh)
                begin
                    visited_next[scan_tgt] = 1'b1;
                    fresh_we               = 1'b1;
                    found_next             = found_reg + CW'(1);
                end
                if (cur_edge_reg == tail_rd_reg)
                begin
                    state_next = S_COPY_RD;
                end
                else
                begin
                    cur_edge_next = scan_link;
                end
            end

            S_COPY_RD:
            begin
                // newest discovery goes on first so the first neighbour ends on top
                if (found_reg != '0)
                begin
                    found_next = found_reg - CW'(1);
                    state_next = S_COPY_WR;
                end
                else if (wl_size_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_POP_RD;
                end
            end

            S_COPY_WR:
            begin
                wl_we        = 1'b1;
                wl_size_next = wl_size_reg + CW'(1);
                state_next   = S_COPY_RD;
            end

            S_FINISH:
            begin
                result_valid_next     = 1'b1;
                result_next.vertex_id = gdfo_pkg::VERTEX_W'(pending_reg);
                result_next.status    = gdfo_pkg::ST_VERTEX;
                result_next.last      = 1'b1;
                pending_valid_next    = 1'b0;
                state_next            = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            vcount_reg        <= gdfo_pkg::VCOUNT_RESET;
            edges_stored_reg  <= '0;
            first_valid_reg   <= '0;
            visited_reg       <= '0;
            wl_size_reg       <= '0;
            found_reg         <= '0;
            emitted_reg       <= '0;
            pending_valid_reg <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            edges_stored_reg  <= edges_stored_next;
            first_valid_reg   <= first_valid_next;
            visited_reg       <= visited_next;
            wl_size_reg       <= wl_size_next;
            found_reg         <= found_next;
            emitted_reg       <= emitted_next;
            pending_valid_reg <= pending_valid_next;
            result_valid_reg  <= result_valid_next;
            if (cfg_we)
            begin
                vcount_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            src_reg <= cmd.source_vertex;
            dst_reg <= cmd.target_vertex;
        end
        pending_reg  <= pending_next;
        cur_edge_reg <= cur_edge_next;
        result_reg   <= result_next;
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (first_we)
        begin
            first_mem[src_idx] <= new_edge;
        end
        first_rd_reg <= first_mem[wl_rd_reg];
    end

    always_ff @(posedge clk)
    begin
        if (tail_we)
        begin
            tail_mem[src_idx] <= new_edge;
        end
        tail_rd_reg <= tail_mem[tail_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wl_we)
        begin
            wl_mem[wl_waddr] <= wl_wdata;
        end
        wl_rd_reg <= wl_mem[wl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (fresh_we)
        begin
            fresh_mem[found_reg[VW-1:0]] <= scan_tgt;
        end
        fresh_rd_reg <= fresh_mem[fresh_raddr];
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> busy)
        else $error("non-final traversal result while sequencer idle");

    a_edge_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status != gdfo_pkg::ST_VERTEX))
            |-> ((result.vertex_id == '0) && result.last))
        else $error("edge answer with nonzero vertex or without last");

    a_edge_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD && !bad_id && !store_full)
            |=> (edges_stored_reg == SW'($past(edges_stored_reg) + SW'(1))))
        else $error("edge count not advanced on accepted edge");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_wl_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (SUM_W'(wl_size_reg) + SUM_W'(found_reg)) <= SUM_W'(MAX_VERTICES))
        else $error("worklist plus discoveries exceed vertex capacity");

endmodule
